### rtl/bwds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwds_pkg
// Shared types and codes of the burn wire deploy sequencer: phase and event
// codes, register indexes, configuration and request/result records.
// ----------------------------------------------------------------------------
package bwds_pkg;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam int IN_TW  = 8;
  localparam int OUT_TW = 16;

  typedef enum logic [2:0] {
    PH_BOOT  = 3'd0,
    PH_WAIT  = 3'd1,
    PH_IDLE  = 3'd2,
    PH_HEAT  = 3'd3,
    PH_COOL  = 3'd4,
    PH_RETRY = 3'd5,
    PH_OPER  = 3'd6,
    PH_FAIL  = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_HEAT     = 3'd1,
    EV_COOL     = 3'd2,
    EV_DEPLOYED = 3'd3,
    EV_RETRY    = 3'd4,
    EV_GAVEUP   = 3'd5
  } event_t;

  localparam logic [2:0] REG_WAIT_BEFORE_DEPLOY = 3'd0;
  localparam logic [2:0] REG_HEAT_TIME          = 3'd1;
  localparam logic [2:0] REG_COOL_TIME          = 3'd2;
  localparam logic [2:0] REG_RETRY_WAIT_TIME    = 3'd3;
  localparam logic [2:0] REG_MAX_ATTEMPTS       = 3'd4;

  localparam logic [31:0] RST_WAIT_BEFORE_DEPLOY = 32'd1800000;
  localparam logic [23:0] RST_HEAT_TIME          = 24'd30000;
  localparam logic [23:0] RST_COOL_TIME          = 24'd60000;
  localparam logic [23:0] RST_RETRY_WAIT_TIME    = 24'd300000;
  localparam logic [3:0]  RST_MAX_ATTEMPTS       = 4'd3;

  typedef struct packed {
    logic [31:0] wait_before_deploy;
    logic [23:0] heat_time;
    logic [23:0] cool_time;
    logic [23:0] retry_wait_time;
    logic [3:0]  max_attempts;
  } cfg_t;

  typedef struct packed {
    logic force_operational;
    logic switch_pressed;
  } req_t;

  typedef struct packed {
    logic [3:0] failed_attempts;
    event_t     event_res;
    phase_t     phase;
    logic       deployed;
    logic       heater_on;
  } res_t;

endpackage

### rtl/bwds_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwds_cfg
// Register bank for the phase limits, written and read over the APB port.
// ----------------------------------------------------------------------------
module bwds_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bwds_pkg::CFG_AW-1:0]   paddr,
  input  logic [bwds_pkg::CFG_DW-1:0]   pwdata,
  output logic [bwds_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output bwds_pkg::cfg_t                cfg
);
  import bwds_pkg::*;

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wait_before_deploy <= RST_WAIT_BEFORE_DEPLOY;
      cfg.heat_time          <= RST_HEAT_TIME;
      cfg.cool_time          <= RST_COOL_TIME;
      cfg.retry_wait_time    <= RST_RETRY_WAIT_TIME;
      cfg.max_attempts       <= RST_MAX_ATTEMPTS;
    end else if (wr_en) begin
      case (idx)
        REG_WAIT_BEFORE_DEPLOY: cfg.wait_before_deploy <= pwdata;
        REG_HEAT_TIME:          cfg.heat_time          <= pwdata[23:0];
        REG_COOL_TIME:          cfg.cool_time          <= pwdata[23:0];
        REG_RETRY_WAIT_TIME:    cfg.retry_wait_time    <= pwdata[23:0];
        REG_MAX_ATTEMPTS:       cfg.max_attempts       <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WAIT_BEFORE_DEPLOY: prdata = cfg.wait_before_deploy;
      REG_HEAT_TIME:          prdata = {8'd0, cfg.heat_time};
      REG_COOL_TIME:          prdata = {8'd0, cfg.cool_time};
      REG_RETRY_WAIT_TIME:    prdata = {8'd0, cfg.retry_wait_time};
      REG_MAX_ATTEMPTS:       prdata = {28'd0, cfg.max_attempts};
      default:                prdata = '0;
    endcase
  end

endmodule

### rtl/bwds_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwds_core
// Input register, phase state and next-state logic, and result register.
// One request per cycle is evaluated against the phase state unless stalled.
// ----------------------------------------------------------------------------
module bwds_core (
  input  logic           clk,
  input  logic           rst,
  input  bwds_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  bwds_pkg::req_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output bwds_pkg::res_t out_item
);
  import bwds_pkg::*;

  logic        in_full;
  req_t        req;
  logic        adv;

  phase_t      phase_reg;
  logic [31:0] phase_ticks;
  logic [3:0]  attempt_count;
  logic        deployed_flag;
  logic        heater_reg;

  phase_t      phase_next;
  logic [31:0] phase_ticks_next;
  logic [3:0]  attempt_count_next;
  logic        deployed_flag_next;
  logic        heater_reg_next;
  event_t      ev;

  logic [31:0] el;
  logic [3:0]  att_inc;

  assign adv      = in_full & (~out_valid | out_ready);
  assign in_ready = ~in_full | adv;

  assign el      = (phase_ticks == '1) ? phase_ticks : phase_ticks + 32'd1;
  assign att_inc = (attempt_count == '1) ? attempt_count : attempt_count + 4'd1;

  always_comb begin
    phase_next         = phase_reg;
    phase_ticks_next   = el;
    attempt_count_next = attempt_count;
    deployed_flag_next = deployed_flag;
    heater_reg_next    = heater_reg;
    ev                 = EV_NONE;
    if (req.force_operational) begin
      heater_reg_next    = 1'b0;
      deployed_flag_next = 1'b1;
      phase_next         = PH_OPER;
      phase_ticks_next   = '0;
    end else begin
      case (phase_reg)
        PH_BOOT: begin
          phase_next       = PH_WAIT;
          phase_ticks_next = '0;
        end
        PH_WAIT: begin
          if (el >= cfg.wait_before_deploy) begin
            phase_next       = PH_IDLE;
            phase_ticks_next = '0;
          end
        end
        PH_IDLE: begin
          phase_ticks_next = '0;
          if (req.switch_pressed) begin
            heater_reg_next = 1'b1;
            phase_next      = PH_HEAT;
            ev              = EV_HEAT;
          end else begin
            heater_reg_next    = 1'b0;
            deployed_flag_next = 1'b1;
            phase_next         = PH_OPER;
            ev                 = EV_DEPLOYED;
          end
        end
        PH_HEAT: begin
          if (el >= {8'd0, cfg.heat_time}) begin
            heater_reg_next  = 1'b0;
            phase_next       = PH_COOL;
            phase_ticks_next = '0;
            ev               = EV_COOL;
          end
          // release wins over timeout
          if (!req.switch_pressed) begin
            heater_reg_next    = 1'b0;
            deployed_flag_next = 1'b1;
            phase_next         = PH_OPER;
            phase_ticks_next   = '0;
            ev                 = EV_DEPLOYED;
          end
        end
        PH_COOL: begin
          if (el >= {8'd0, cfg.cool_time}) begin
            phase_ticks_next = '0;
            if (!req.switch_pressed) begin
              heater_reg_next    = 1'b0;
              deployed_flag_next = 1'b1;
              phase_next         = PH_OPER;
              ev                 = EV_DEPLOYED;
            end else begin
              attempt_count_next = att_inc;
              if (att_inc >= cfg.max_attempts) begin
                phase_next = PH_FAIL;
                ev         = EV_GAVEUP;
              end else begin
                phase_next = PH_RETRY;
                ev         = EV_RETRY;
              end
            end
          end
        end
        PH_RETRY: begin
          if (el >= {8'd0, cfg.retry_wait_time}) begin
            phase_next       = PH_IDLE;
            phase_ticks_next = '0;
          end
          if (!req.switch_pressed) begin
            heater_reg_next    = 1'b0;
            deployed_flag_next = 1'b1;
            phase_next         = PH_OPER;
            phase_ticks_next   = '0;
            ev                 = EV_DEPLOYED;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full       <= 1'b0;
      out_valid     <= 1'b0;
      phase_reg     <= PH_BOOT;
      phase_ticks   <= '0;
      attempt_count <= '0;
      deployed_flag <= 1'b0;
      heater_reg    <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_full <= 1'b1;
      end else if (adv) begin
        in_full <= 1'b0;
      end
      if (adv) begin
        out_valid     <= 1'b1;
        phase_reg     <= phase_next;
        phase_ticks   <= phase_ticks_next;
        attempt_count <= attempt_count_next;
        deployed_flag <= deployed_flag_next;
        heater_reg    <= heater_reg_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_item;
    end
    if (adv) begin
      out_item.heater_on       <= heater_reg_next;
      out_item.deployed        <= deployed_flag_next;
      out_item.phase           <= phase_next;
      out_item.event_res       <= ev;
      out_item.failed_attempts <= attempt_count_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_heater_only_heat: assert property (@(posedge clk) disable iff (rst)
    heater_reg |-> phase_reg == PH_HEAT)
    else $error("heater on outside heat phase");

  a_deployed_oper: assert property (@(posedge clk) disable iff (rst)
    deployed_flag |-> phase_reg == PH_OPER)
    else $error("deployed flag outside operational phase");

  a_attempts_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> attempt_count >= $past(attempt_count))
    else $error("attempt count decreased");

  a_ticks_cleared: assert property (@(posedge clk) disable iff (rst)
    adv && (phase_next != phase_reg) |=> phase_ticks == '0)
    else $error("phase ticks not cleared on phase change");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(phase_reg) && $stable(attempt_count))
    else $error("state moved without a request");
`endif

endmodule

### rtl/burn_wire_deploy_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// burn_wire_deploy_sequencer_unit
// Burn wire antenna deploy sequencer: one request per millisecond tick,
// one result per request with heater drive, phase and event.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  tick request (switch, force)
//   m_*      out  m_tvalid/m_tready  result (heater, deployed, phase, ...)
//   apb      in   psel/penable       phase limit registers, always ready
//
// a request is accepted into the input register, then its result is
// registered; one request per cycle is sustained while results are taken
// the phase state is updated in the same cycle the result is registered
// a stalled result holds and the input register still takes one request
// rst is synchronous and restores boot phase and register reset values
// ----------------------------------------------------------------------------
module burn_wire_deploy_sequencer_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [0] switch_pressed, [1] force_operational, [7:2] zero
  input  logic [bwds_pkg::IN_TW-1:0]    s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [0] heater_on, [1] deployed, [4:2] phase, [7:5] event_res,
  // [11:8] failed_attempts, [15:12] zero
  output logic [bwds_pkg::OUT_TW-1:0]   m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bwds_pkg::CFG_AW-1:0]   paddr,
  input  logic [bwds_pkg::CFG_DW-1:0]   pwdata,
  output logic [bwds_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);
  import bwds_pkg::*;

  cfg_t cfg;
  req_t in_item;
  res_t out_item;

  assign in_item.switch_pressed    = s_tdata[0];
  assign in_item.force_operational = s_tdata[1];

  assign m_tdata = {4'd0, out_item.failed_attempts, out_item.event_res,
                    out_item.phase, out_item.deployed, out_item.heater_on};

  bwds_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bwds_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (out_item)
  );

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the burn wire deploy sequencer. Tick requests are
// streamed in while a per-request tracker of the phase machine predicts
// every result; results are compared field by field in order. The phase limit
// registers are rewritten between phases, including their extremes, under
// several sender and receiver idling patterns and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import bwds_pkg::*;

  localparam int  LIMIT     = 300000;
  localparam int  HOLD_LEN  = 60;
  localparam int  PHASE_LEN = 170;
  localparam req_t PRESS   = '{force_operational: 1'b0, switch_pressed: 1'b1};
  localparam req_t RELEASE = '{force_operational: 1'b0, switch_pressed: 1'b0};

  class deploy_tracker;
    cfg_t        cfg;
    phase_t      phase;
    logic [31:0] ticks;
    logic [3:0]  attempts;
    logic        deployed;
    logic        heater;
    res_t        status_q[$];
    int          errors;
    int          mismatches;

    function void clear();
      cfg.wait_before_deploy = RST_WAIT_BEFORE_DEPLOY;
      cfg.heat_time          = RST_HEAT_TIME;
      cfg.cool_time          = RST_COOL_TIME;
      cfg.retry_wait_time    = RST_RETRY_WAIT_TIME;
      cfg.max_attempts       = RST_MAX_ATTEMPTS;
      phase      = PH_BOOT;
      ticks      = '0;
      attempts   = '0;
      deployed   = 1'b0;
      heater     = 1'b0;
      errors     = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_WAIT_BEFORE_DEPLOY: cfg.wait_before_deploy = value;
        REG_HEAT_TIME:          cfg.heat_time = value[23:0];
        REG_COOL_TIME:          cfg.cool_time = value[23:0];
        REG_RETRY_WAIT_TIME:    cfg.retry_wait_time = value[23:0];
        REG_MAX_ATTEMPTS:       cfg.max_attempts = value[3:0];
        default: ;
      endcase
    endfunction

    function void enter(phase_t p);
      phase = p;
      ticks = '0;
    endfunction

    function event_t deploy_done();
      heater   = 1'b0;
      deployed = 1'b1;
      enter(PH_OPER);
      return EV_DEPLOYED;
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    function void take_tick(req_t r);
      event_t      ev;
      logic [31:0] el;
      res_t        res;
      ev = EV_NONE;
      if (ticks != 32'hFFFF_FFFF) ticks++;
      el = ticks;
      if (r.force_operational) begin
        heater   = 1'b0;
        deployed = 1'b1;
        enter(PH_OPER);
      end else begin
        case (phase)
          PH_BOOT: enter(PH_WAIT);
          PH_WAIT: begin
            if (el >= cfg.wait_before_deploy) enter(PH_IDLE);
          end
          PH_IDLE: begin
            if (r.switch_pressed) begin
              heater = 1'b1;
              enter(PH_HEAT);
              ev = EV_HEAT;
            end else begin
              ev = deploy_done();
            end
          end
          PH_HEAT: begin
            if (el >= {8'd0, cfg.heat_time}) begin
              heater = 1'b0;
              enter(PH_COOL);
              ev = EV_COOL;
            end
            if (!r.switch_pressed) ev = deploy_done();
          end
          PH_COOL: begin
            if (el >= {8'd0, cfg.cool_time}) begin
              if (!r.switch_pressed) begin
                ev = deploy_done();
              end else begin
                if (attempts < 4'd15) attempts++;
                if (attempts >= cfg.max_attempts) begin
                  enter(PH_FAIL);
                  ev = EV_GAVEUP;
                end else begin
                  enter(PH_RETRY);
                  ev = EV_RETRY;
                end
              end
            end
          end
          PH_RETRY: begin
            if (el >= {8'd0, cfg.retry_wait_time}) enter(PH_IDLE);
            if (!r.switch_pressed) ev = deploy_done();
          end
          default: ;
        endcase
      end
      res.heater_on       = heater;
      res.deployed        = deployed;
      res.phase           = phase;
      res.event_res       = ev;
      res.failed_attempts = attempts;
      status_q.push_back(res);
    endfunction

    function void compare(string name, int want, int got);
      if (want != got) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_status(logic [OUT_TW-1:0] data);
      res_t want;
      res_t got;
      got = res_t'(data[$bits(res_t)-1:0]);
      if (status_q.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) $display("%0t: result with no request pending", $time);
        return;
      end
      want = status_q.pop_front();
      compare("heater_on", want.heater_on, got.heater_on);
      compare("deployed", want.deployed, got.deployed);
      compare("phase", int'(want.phase), int'(got.phase));
      compare("event_res", int'(want.event_res), int'(got.event_res));
      compare("failed_attempts", want.failed_attempts, got.failed_attempts);
      compare("pad", 0, int'(data[OUT_TW-1:$bits(res_t)]));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_TW-1:0]  s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_TW-1:0] m_tdata;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  deploy_tracker book = new();
  int            idle_mode = 0;
  bit            aim_deploy;
  bit            hold_req = 1'b0;
  bit            hold_done = 1'b0;
  int            hold_left = 0;
  int            cycles = 0;

  burn_wire_deploy_sequencer_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic bit coin(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // request and result bookkeeping
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) book.take_tick(req_t'(s_tdata[$bits(req_t)-1:0]));
    if (!rst && m_tvalid && m_tready) book.check_status(m_tdata);
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !coin(idle_mode == 2 ? 57 : idle_mode == 3 ? 19 : 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[burn_wire_deploy_sequencer_unit] ERROR");
      $finish;
    end
  end

  task automatic send_tick(input req_t r);
    while (coin(idle_mode == 1 ? 57 : idle_mode == 3 ? 19 : 0)) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TW - $bits(req_t)){1'b0}}, r};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    book.set_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // keep the switch (mostly) pressed while the sequence runs to reach retries
  function automatic req_t pick_tick();
    req_t r;
    if (book.phase inside {PH_OPER, PH_FAIL}) begin
      r.switch_pressed    = 1'($urandom_range(0, 1));
      r.force_operational = 1'($urandom_range(0, 1));
    end else begin
      r.force_operational = ($urandom_range(0, 499) == 0);
      r.switch_pressed    = aim_deploy ? ($urandom_range(0, 24) != 0) : 1'b1;
    end
    return r;
  endfunction

  initial begin
    logic [3:0] max_pick;
    book.clear();
    aim_deploy = 1'($urandom_range(0, 1));
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // default limits: boot then a long wait
    send_tick(PRESS);
    send_tick(RELEASE);
    drain();
    write_reg(REG_WAIT_BEFORE_DEPLOY, 32'hFFFF_FFFF);
    send_tick(PRESS);
    drain();
    write_reg(REG_WAIT_BEFORE_DEPLOY, 32'd0);
    write_reg(REG_HEAT_TIME, 32'h00FF_FFFF);
    write_reg(REG_COOL_TIME, 32'h00FF_FFFF);
    write_reg(REG_RETRY_WAIT_TIME, 32'h00FF_FFFF);
    send_tick(RELEASE);
    send_tick(PRESS);
    send_tick(PRESS);
    drain();
    write_reg(REG_HEAT_TIME, 32'd0);
    send_tick(PRESS);
    // released during cooling before timeout has no effect
    send_tick(RELEASE);
    send_tick(PRESS);
    drain();
    write_reg(REG_COOL_TIME, 32'd0);
    send_tick(PRESS);
    send_tick(PRESS);
    drain();
    write_reg(REG_RETRY_WAIT_TIME, 32'd0);
    send_tick(PRESS);
    send_tick(PRESS);
    send_tick(PRESS);
    send_tick(PRESS);
    send_tick(PRESS);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      idle_mode = ph;
      case (ph)
        0:       max_pick = 4'd15;
        1:       max_pick = 4'd0;
        2:       max_pick = 4'd1;
        default: max_pick = 4'($urandom_range(0, 15));
      endcase
      write_reg(REG_WAIT_BEFORE_DEPLOY, 32'($urandom_range(0, 8)));
      write_reg(REG_HEAT_TIME, 32'($urandom_range(0, 6)));
      write_reg(REG_COOL_TIME, 32'($urandom_range(0, 6)));
      write_reg(REG_RETRY_WAIT_TIME, 32'($urandom_range(0, 6)));
      write_reg(REG_MAX_ATTEMPTS, 32'(max_pick));
      if (ph == 0) hold_req = 1'b1;
      repeat (PHASE_LEN) send_tick(pick_tick());
    end

    drain();
    repeat (10) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("[burn_wire_deploy_sequencer_unit] OK");
    end else begin
      $display("[burn_wire_deploy_sequencer_unit] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/bwds_pkg.sv
rtl/bwds_cfg.sv
rtl/bwds_core.sv
rtl/burn_wire_deploy_sequencer_unit.sv
verif/tb_top.sv
